// ===== src/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// Used by spq_ctrl, spq_datapath and sorted_priority_queue_unit; no dependencies.
package spq_pkg;

  localparam int DATA_W    = 32;
  localparam int CNT_OUT_W = 5;

  typedef logic [1:0]               func_t;
  typedef logic [1:0]               status_t;
  typedef logic signed [DATA_W-1:0] word_t;

  localparam func_t OP_INSERT = 2'd0;
  localparam func_t OP_REMOVE = 2'd1;
  localparam func_t OP_CLEAR  = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  typedef struct packed {
    func_t func;
    word_t key_in;
    word_t priority_in;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    word_t                key_out;
    logic [CNT_OUT_W-1:0] item_count;
  } out_item_t;

  typedef struct packed {
    word_t key;
    word_t prio;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_CMP,
    S_FIN
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic    take_item;
    logic    rd_en;
    logic    rd_front;
    logic    wr_en;
    logic    wr_new;
    logic    idx_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    load_out;
    status_t out_status;
    logic    out_key_rd;
  } spq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_t func;
    logic  full;
    logic  empty;
    logic  idx_zero;
    logic  prio_ge;
    logic  out_free;
  } spq_stat_t;

endpackage

// ===== src/spq_ctrl.sv =====
// Sequencer for the sorted priority queue: decodes an operation and steps the
// datapath through the insert shift or the remove read. Depends on spq_pkg.
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  ctl_state_t state_r, state_nxt;
  status_t    st_code_r, st_code_nxt;
  logic       key_rd_r, key_rd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      st_code_r <= ST_OK;
      key_rd_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      st_code_r <= st_code_nxt;
      key_rd_r  <= key_rd_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    st_code_nxt = st_code_r;
    key_rd_nxt  = key_rd_r;
    cmd         = '0;
    cmd.out_status = st_code_r;
    cmd.out_key_rd = key_rd_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          st_code_nxt   = ST_OK;
          key_rd_nxt    = 1'b0;
          state_nxt     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.func)
          OP_INSERT: begin
            if (stat.full) begin
              st_code_nxt = ST_FULL;
              state_nxt   = S_FIN;
            end else begin
              state_nxt = S_INS_RD;
            end
          end
          OP_REMOVE: begin
            if (stat.empty) begin
              st_code_nxt = ST_EMPTY;
            end else begin
              // Read the front entry and pop it in the same cycle
              cmd.rd_en    = 1'b1;
              cmd.rd_front = 1'b1;
              cmd.cnt_dec  = 1'b1;
              key_rd_nxt   = 1'b1;
            end
            state_nxt = S_FIN;
          end
          OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = S_FIN;
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_INS_RD: begin
        if (stat.idx_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.prio_ge) begin
          // Move the stored entry one slot toward the back
          cmd.wr_en   = 1'b1;
          cmd.idx_dec = 1'b1;
          state_nxt   = S_INS_RD;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/spq_datapath.sv =====
// Datapath of the sorted priority queue: circular entry memory, head and count
// registers, insert index, compare and the output register. Depends on spq_pkg.
module spq_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::in_item_t  in_data,
  input  spq_pkg::spq_cmd_t  cmd,
  output spq_pkg::spq_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  entry_t          mem [DEPTH];
  entry_t          rd_data_r;
  in_item_t        item_r;
  logic [CW-1:0]   idx_r, count_r;
  logic [AW-1:0]   head_r;
  logic            out_valid_r;
  out_item_t       out_data_r;

  logic [CW-1:0]   idx_m1;
  logic [AW-1:0]   rd_addr, wr_addr, head_inc;
  entry_t          wr_entry;
  logic            out_free;

  assign idx_m1   = idx_r - 1'b1;
  assign head_inc = head_r + 1'b1;
  assign rd_addr  = cmd.rd_front ? head_r : head_r + idx_m1[AW-1:0];
  assign wr_addr  = head_r + idx_r[AW-1:0];

  always_comb begin
    if (cmd.wr_new) begin
      wr_entry.key  = item_r.key_in;
      wr_entry.prio = item_r.priority_in;
    end else begin
      wr_entry = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Latch the operation and start the insert scan at the back
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_r <= in_data;
      idx_r  <= count_r;
    end else if (cmd.idx_dec) begin
      idx_r <= idx_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
    end else if (cmd.cnt_clr) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - 1'b1;
      head_r  <= head_inc;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.status     <= cmd.out_status;
      out_data_r.key_out    <= cmd.out_key_rd ? rd_data_r.key : '0;
      out_data_r.item_count <= CNT_OUT_W'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.func     = item_r.func;
  assign stat.full     = (count_r == CAP_C);
  assign stat.empty    = (count_r == '0);
  assign stat.idx_zero = (idx_r == '0);
  assign stat.prio_ge  = ($signed(rd_data_r.prio) >= $signed(item_r.priority_in));
  assign stat.out_free = out_free;

endmodule

// ===== src/sorted_priority_queue_unit.sv =====
// Sorted-list minimum priority queue, top level.
// Channels: in_valid/in_stall/in_data carry one operation (insert key with a
// Q16.16 priority, remove minimum, clear); out_valid/out_stall/out_data carry
// one result per operation: status, removed key and the entry count after it.
// A transfer happens on a rising edge with valid high and stall low.
// The queue is a circular memory of 2**clog2(CAPACITY) entries kept in sorted
// order from a head pointer, so a remove only reads the head and advances it.
// An insert walks from the back, one memory read and one write per stored
// entry that moves, because the memory has one read and one write port.
// Remove, clear, rejected operations and unused codes go from dispatch to
// finish; an insert passes through a read and a compare state per entry that
// moves and writes the new entry on reaching a smaller entry or index zero.
// One operation is in flight at a time; in_stall stays high from the
// transfer until the result is loaded, and the next transfer can happen on
// the edge after that.
// Reset empties the queue and drops any pending result; memory contents
// are left as they are. While the receiver stalls, the finished result holds
// in the output register and the controller waits before loading the next.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
module sorted_priority_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second operation taken while one is in flight");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over a pending result");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_EMPTY) |->
      (out_data.item_count == '0 && out_data.key_out == '0))
    else $error("empty status with nonzero count or key");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> out_data.key_out == '0)
    else $error("full status with nonzero key");

endmodule
